@@ src/phw_pkg.sv @@
`default_nettype none
package phw_pkg;

	localparam int TIME_W = 32;
	localparam int DIV_STEPS = 32;
	localparam int CNT_W = $clog2(DIV_STEPS);

	localparam logic [2:0] REQ_ADVANCE = 3'd0;
	localparam logic [2:0] REQ_PLAY    = 3'd1;
	localparam logic [2:0] REQ_PAUSE   = 3'd2;
	localparam logic [2:0] REQ_STOP    = 3'd3;
	localparam logic [2:0] REQ_SEEK    = 3'd4;

	localparam logic [1:0] MODE_ONCE     = 2'd0;
	localparam logic [1:0] MODE_LOOP     = 2'd1;
	localparam logic [1:0] MODE_PINGPONG = 2'd2;
	localparam logic [1:0] MODE_HOLD     = 2'd3;

	localparam logic [1:0] REG_DURATION  = 2'd0;
	localparam logic [1:0] REG_SPEED     = 2'd1;
	localparam logic [1:0] REG_WRAP_MODE = 2'd2;

	typedef struct packed {
		logic [2:0]          req_type;
		logic [15:0]         delta_time;
		logic signed [31:0]  seek_time;
	} req_t;

	typedef struct packed {
		logic signed [31:0]  position;
		logic                is_playing;
		logic                going_forward;
		logic                finished;
		logic                looped;
	} rsp_t;

	typedef struct packed {
		logic [30:0]         duration;
		logic signed [12:0]  speed;
		logic [1:0]          wrap_mode;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic eval;
		logic div_step;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
	} dp_sts_t;

endpackage
`default_nettype wire

@@ src/playhead_wrap_timer.sv @@
// channel  | signals                                   | beat
// ---------+-------------------------------------------+----------------------------
// request  | req_valid, req_ready, req_data            | one command
// response | rsp_valid, rsp_ready, rsp_data            | playhead state after command
// config   | psel, penable, pwrite, paddr, pwdata, ... | one register write or read
//
// after accept a command passes the multiply and evaluate states, then commits to the result register;
// a loop-mode wrap first runs a bit-serial remainder by the duration before the commit
// one command at a time: req_ready is high only while the controller is idle
// a waiting result holds in the output register and stalls the next commit
// reset clears playhead, direction, play flag and registers to their defaults
`default_nettype none
module playhead_wrap_timer
	import phw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire req_t        req_data,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output rsp_t             rsp_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	phw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	phw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	phw_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req_data),
		.cfg    (cfg),
		.rsp    (rsp_data)
	);

endmodule
`default_nettype wire

@@ src/phw_regs.sv @@
`default_nettype none
module phw_regs
	import phw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic [30:0]        duration_q;
	logic signed [12:0] speed_q;
	logic [1:0]         wrap_mode_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q  <= '0;
			speed_q     <= 13'sd256;
			wrap_mode_q <= MODE_ONCE;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_DURATION:  duration_q  <= pwdata[30:0];
				REG_SPEED:     speed_q     <= signed'(pwdata[12:0]);
				REG_WRAP_MODE: wrap_mode_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_DURATION:  prdata = {1'b0, duration_q};
			REG_SPEED:     prdata = 32'(speed_q);
			REG_WRAP_MODE: prdata = {30'd0, wrap_mode_q};
			default:       prdata = '0;
		endcase
	end

	assign cfg.duration  = duration_q;
	assign cfg.speed     = speed_q;
	assign cfg.wrap_mode = wrap_mode_q;

endmodule
`default_nettype wire

@@ src/phw_ctrl.sv @@
`default_nettype none
module phw_ctrl
	import phw_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_ready,
	output logic         rsp_valid,
	input  wire logic    rsp_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_EVAL = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

	assign cmd.load     = req_valid && req_ready;
	assign cmd.mul      = (state_q == ST_MUL);
	assign cmd.eval     = (state_q == ST_EVAL);
	assign cmd.div_step = (state_q == ST_DIV);
	assign cmd.commit   = (state_q == ST_DONE) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_EVAL;
				ST_EVAL: begin
					cnt_q <= CNT_W'(DIV_STEPS - 1);
					state_q <= sts.need_div ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ src/phw_dp.sv @@
`default_nettype none
module phw_dp
	import phw_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire dp_cmd_t cmd,
	output dp_sts_t      sts,
	input  wire req_t    req,
	input  wire cfg_t    cfg,
	output rsp_t         rsp
);

	req_t               req_q;
	logic signed [29:0] prod_q;
	logic signed [31:0] playhead_q;
	logic               running_q;
	logic               fwd_q;
	logic [31:0]        nxt_pos_q;
	logic               nxt_run_q;
	logic               nxt_fwd_q;
	logic               fin_q;
	logic               lop_q;
	logic               div_on_q;
	logic               div_neg_q;
	logic [31:0]        div_num_q;
	logic [30:0]        div_rem_q;
	rsp_t               rsp_q;

	logic signed [16:0] dt_s;
	logic signed [29:0] prod_c;
	logic [29:0]        mag_c;
	logic signed [22:0] mag_s;
	logic signed [22:0] step_c;
	logic               dur_nz;
	logic               flip;
	logic signed [33:0] t_c;
	logic signed [33:0] neg_t;
	logic signed [33:0] dur_s;
	logic signed [33:0] refl_c;
	logic               ge;
	logic               lt;
	logic [31:0]        pos_c;
	logic               run_c;
	logic               fwd_c;
	logic               fin_c;
	logic               lop_c;
	logic               div_c;
	logic               neg_c;
	logic [31:0]        num_c;
	logic [31:0]        rem_sh;
	logic [31:0]        dur32;
	logic [31:0]        pos_fin;

	assign dt_s   = signed'({1'b0, req_q.delta_time});
	assign prod_c = dt_s * cfg.speed;

	assign dur_nz = (cfg.duration != '0);
	assign dur32  = {1'b0, cfg.duration};
	assign dur_s  = signed'({3'b000, cfg.duration});
	assign mag_c  = prod_q[29] ? 30'(-prod_q) : 30'(prod_q);
	assign mag_s  = signed'({1'b0, mag_c[29:8]});
	assign flip   = prod_q[29] ^ ((cfg.wrap_mode == MODE_PINGPONG) && !fwd_q && dur_nz);
	assign step_c = flip ? -mag_s : mag_s;
	assign t_c    = 34'(playhead_q) + 34'(step_c);
	assign neg_t  = -t_c;
	assign refl_c = dur_s + dur_s - t_c;
	assign ge     = (t_c >= dur_s);
	assign lt     = t_c[33];

	always_comb begin
		pos_c = playhead_q;
		run_c = running_q;
		fwd_c = fwd_q;
		fin_c = 1'b0;
		lop_c = 1'b0;
		div_c = 1'b0;
		neg_c = 1'b0;
		num_c = t_c[31:0];
		case (req_q.req_type)
			REQ_ADVANCE: begin
				if (running_q) begin
					if (!dur_nz) begin
						if (t_c[33:31] == 3'b000 || t_c[33:31] == 3'b111) begin
							pos_c = t_c[31:0];
						end else begin
							pos_c = t_c[33] ? 32'h8000_0000 : 32'h7fff_ffff;
						end
					end else begin
						pos_c = t_c[31:0];
						case (cfg.wrap_mode)
							MODE_LOOP: begin
								if (ge) begin
									div_c = 1'b1;
									lop_c = 1'b1;
								end else if (lt) begin
									div_c = 1'b1;
									neg_c = 1'b1;
									num_c = neg_t[31:0];
									lop_c = 1'b1;
								end
							end
							MODE_PINGPONG: begin
								if (ge) begin
									pos_c = refl_c[33] ? '0 : refl_c[31:0];
									fwd_c = 1'b0;
									lop_c = 1'b1;
								end else if (lt) begin
									pos_c = (neg_t > dur_s) ? dur32 : neg_t[31:0];
									fwd_c = 1'b1;
									lop_c = 1'b1;
								end
							end
							default: begin
								if (ge) begin
									pos_c = dur32;
									run_c = 1'b0;
									fin_c = 1'b1;
								end else if (lt) begin
									pos_c = '0;
									run_c = 1'b0;
									fin_c = 1'b1;
								end
							end
						endcase
					end
				end
			end
			REQ_PLAY:  run_c = 1'b1;
			REQ_PAUSE: run_c = 1'b0;
			REQ_STOP: begin
				run_c = 1'b0;
				pos_c = '0;
				fwd_c = 1'b1;
			end
			REQ_SEEK: begin
				pos_c = req_q.seek_time;
				if (dur_nz) begin
					if (req_q.seek_time[31]) begin
						pos_c = '0;
					end else if (req_q.seek_time > signed'(dur32)) begin
						pos_c = dur32;
					end
				end
			end
			default: ;
		endcase
	end

	assign sts.need_div = div_c;

	assign rem_sh = {div_rem_q, div_num_q[31]};

	always_comb begin
		if (!div_on_q) begin
			pos_fin = nxt_pos_q;
		end else if (div_neg_q) begin
			pos_fin = (div_rem_q != '0) ? (dur32 - {1'b0, div_rem_q}) : '0;
		end else begin
			pos_fin = {1'b0, div_rem_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.mul) prod_q <= prod_c;
		if (cmd.eval) begin
			nxt_pos_q <= pos_c;
			nxt_run_q <= run_c;
			nxt_fwd_q <= fwd_c;
			fin_q     <= fin_c;
			lop_q     <= lop_c;
			div_on_q  <= div_c;
			div_neg_q <= neg_c;
			div_num_q <= num_c;
			div_rem_q <= '0;
		end else if (cmd.div_step) begin
			div_num_q <= {div_num_q[30:0], 1'b0};
			div_rem_q <= (rem_sh >= dur32) ? 31'(rem_sh - dur32) : rem_sh[30:0];
		end
		if (cmd.commit) begin
			rsp_q.position      <= signed'(pos_fin);
			rsp_q.is_playing    <= nxt_run_q;
			rsp_q.going_forward <= nxt_fwd_q;
			rsp_q.finished      <= fin_q;
			rsp_q.looped        <= lop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playhead_q <= '0;
			running_q  <= 1'b0;
			fwd_q      <= 1'b1;
		end else if (cmd.commit) begin
			playhead_q <= signed'(pos_fin);
			running_q  <= nxt_run_q;
			fwd_q      <= nxt_fwd_q;
		end
	end

	assign rsp = rsp_q;

endmodule
`default_nettype wire
